[hdl/rcbs_pkg.sv]
`default_nettype none
package rcbs_pkg;

    localparam int ROWS_W = 20;
    localparam int STATUS_W = 2;

    // fixed points of the bucket family
    localparam int MIN_BUCKET = 8;
    localparam int SMALL_CAP = 16;
    localparam int POW_TOP = 512;
    localparam int MID_BUCKET = 768;
    localparam int OCT_BASE = 1024;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK = 2'd0;
    localparam status_t ST_ZERO_ROWS = 2'd1;
    localparam status_t ST_OVER_CAP = 2'd2;
    localparam status_t ST_ZERO_CAP = 2'd3;

    typedef logic [1:0] pc_t;
    localparam pc_t PC_ENTRY = 2'd0;
    localparam pc_t PC_SMALL = 2'd1;
    localparam pc_t PC_WALK = 2'd2;
    localparam pc_t PC_CLOSE = 2'd3;

    typedef logic [1:0] cond_t;
    localparam cond_t COND_NONE = 2'd0;
    localparam cond_t COND_LIST_OK = 2'd1;
    localparam cond_t COND_CAP_SMALL = 2'd2;
    localparam cond_t COND_V_GE_CAP = 2'd3;

    typedef logic [1:0] emit_t;
    localparam emit_t EMIT_NONE = 2'd0;
    localparam emit_t EMIT_ALWAYS = 2'd1;
    localparam emit_t EMIT_UNLESS = 2'd2;

    typedef logic [1:0] src_t;
    localparam src_t SRC_SEL = 2'd0;
    localparam src_t SRC_V = 2'd1;
    localparam src_t SRC_CAP = 2'd2;

    typedef struct packed {
        cond_t cond;
        pc_t   target;
        logic  stay;
        emit_t emit;
        src_t  src;
        logic  last;
        logic  advance;
    } uword_t;

    typedef struct packed {
        logic fire;
        src_t src;
        logic last;
        logic advance;
    } ctrl_t;

    typedef struct packed {
        logic list_ok;
        logic cap_small;
        logic v_ge_cap;
    } flags_t;

    // control store
    function automatic uword_t ucode_rom(input pc_t pc);
        uword_t w;
        begin
            case (pc)
                // select result or error, or branch into the family walk
                PC_ENTRY: w = '{COND_LIST_OK, PC_SMALL, 1'b0, EMIT_UNLESS, SRC_SEL, 1'b1, 1'b0};
                PC_SMALL: w = '{COND_CAP_SMALL, PC_CLOSE, 1'b0, EMIT_NONE, SRC_CAP, 1'b0, 1'b0};
                // emit canonical buckets below the capacity
                PC_WALK:  w = '{COND_V_GE_CAP, PC_CLOSE, 1'b1, EMIT_UNLESS, SRC_V, 1'b0, 1'b1};
                PC_CLOSE: w = '{COND_NONE, PC_ENTRY, 1'b0, EMIT_ALWAYS, SRC_CAP, 1'b1, 1'b0};
                default:  w = '{COND_NONE, PC_ENTRY, 1'b0, EMIT_NONE, SRC_CAP, 1'b0, 1'b0};
            endcase
            return w;
        end
    endfunction

endpackage
`default_nettype wire

[hdl/rcbs_seq.sv]
`default_nettype none
module rcbs_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire rcbs_pkg::flags_t flags,
    output logic                 busy,
    output rcbs_pkg::ctrl_t      ctrl
);

    rcbs_pkg::pc_t    pc_reg;
    rcbs_pkg::pc_t    pc_next;
    logic             busy_reg;
    logic             busy_next;
    rcbs_pkg::uword_t uw;
    logic             cond;
    logic             fire;

    always_comb
    begin
        uw = rcbs_pkg::ucode_rom(pc_reg);
        case (uw.cond)
            rcbs_pkg::COND_NONE:      cond = 1'b0;
            rcbs_pkg::COND_LIST_OK:   cond = flags.list_ok;
            rcbs_pkg::COND_CAP_SMALL: cond = flags.cap_small;
            rcbs_pkg::COND_V_GE_CAP:  cond = flags.v_ge_cap;
            default:                  cond = 1'b0;
        endcase
        fire = busy_reg && ((uw.emit == rcbs_pkg::EMIT_ALWAYS) ||
                            ((uw.emit == rcbs_pkg::EMIT_UNLESS) && !cond));
        if (cond)
            pc_next = uw.target;
        else if (uw.stay)
            pc_next = pc_reg;
        else
            pc_next = pc_reg + 2'd1;
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (fire && uw.last)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= rcbs_pkg::PC_ENTRY;
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (accept)
                pc_reg <= rcbs_pkg::PC_ENTRY;
            else if (busy_reg)
                pc_reg <= pc_next;
        end
    end

    assign busy         = busy_reg;
    assign ctrl.fire    = fire;
    assign ctrl.src     = uw.src;
    assign ctrl.last    = uw.last;
    assign ctrl.advance = fire && uw.advance;

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && uw.last) |=> !busy_reg)
        else $error("busy still set after final item result");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && pc_reg == rcbs_pkg::PC_ENTRY))
        else $error("sequencer did not enter program on accept");

    a_no_idle_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !fire)
        else $error("result emitted while idle");

endmodule
`default_nettype wire

[hdl/rcbs_dp.sv]
`default_nettype none
module rcbs_dp #(
    parameter int ROW_BITS = 20
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic                            cmd,
    input  wire logic [rcbs_pkg::ROWS_W-1:0]     active_rows,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rcbs_pkg::ROWS_W-1:0]     cfg_wr_data,
    input  wire rcbs_pkg::ctrl_t                 ctrl,
    output rcbs_pkg::flags_t                     flags,
    output logic                                 result_valid,
    output logic [rcbs_pkg::ROWS_W-1:0]          bucket_rows,
    output rcbs_pkg::status_t                    status,
    output logic                                 last
);

    localparam int CW = ROW_BITS + 1;
    localparam int PW = $clog2(ROW_BITS);

    logic [ROW_BITS-1:0]         cap_reg;
    logic                        list_reg;
    rcbs_pkg::status_t           err_reg;
    logic [ROW_BITS-1:0]         x_reg;
    logic [PW-1:0]               p_reg;
    logic [CW-1:0]               v_reg;
    logic [CW-1:0]               base_reg;
    logic                        result_valid_reg;
    logic [rcbs_pkg::ROWS_W-1:0] bucket_reg;
    rcbs_pkg::status_t           status_reg;
    logic                        last_reg;

    logic [ROW_BITS-1:0]         rows_m;
    logic [ROW_BITS-1:0]         x_in;
    logic [PW-1:0]               p_in;
    rcbs_pkg::status_t           err_in;
    logic [CW-1:0]               v_next;
    logic [CW-1:0]               base_next;
    logic [PW-1:0]               sh;
    logic [CW-1:0]               canon;
    logic [CW-1:0]               cap_x;
    logic [ROW_BITS-1:0]         sel;
    logic                        cap_small;
    logic [rcbs_pkg::ROWS_W-1:0] bucket_next;
    rcbs_pkg::status_t           status_next;

    assign cap_x     = {1'b0, cap_reg};
    assign cap_small = cap_reg < ROW_BITS'(rcbs_pkg::SMALL_CAP);

    // error check and leading-one position of rows-1, taken on accept
    always_comb
    begin
        rows_m = active_rows[ROW_BITS-1:0];
        x_in   = rows_m - ROW_BITS'(1);
        p_in   = '0;
        for (int i = 0; i < ROW_BITS; i++)
        begin
            if (x_in[i])
                p_in = PW'(i);
        end
        if (cap_reg == '0)
            err_in = rcbs_pkg::ST_ZERO_CAP;
        else if (!cmd && rows_m == '0)
            err_in = rcbs_pkg::ST_ZERO_ROWS;
        else if (!cmd && rows_m > cap_reg)
            err_in = rcbs_pkg::ST_OVER_CAP;
        else
            err_in = rcbs_pkg::ST_OK;
    end

    // canonical round-up of rows, capped
    always_comb
    begin
        sh = p_reg - PW'(2);
        if (x_reg < ROW_BITS'(rcbs_pkg::MIN_BUCKET))
            canon = CW'(rcbs_pkg::MIN_BUCKET);
        else if (x_reg < ROW_BITS'(rcbs_pkg::POW_TOP))
            canon = CW'(1) << (p_reg + PW'(1));
        else if (x_reg < ROW_BITS'(rcbs_pkg::MID_BUCKET))
            canon = CW'(rcbs_pkg::MID_BUCKET);
        else if (x_reg < ROW_BITS'(rcbs_pkg::OCT_BASE))
            canon = CW'(rcbs_pkg::OCT_BASE);
        else
            // quarter-octave ceiling: keep top three bits, bump, shift back
            canon = (({1'b0, x_reg} >> sh) + CW'(1)) << sh;
        if (cap_small || canon > cap_x)
            sel = cap_reg;
        else
            sel = canon[ROW_BITS-1:0];
    end

    // next canonical bucket for the family walk
    always_comb
    begin
        if (v_reg < CW'(rcbs_pkg::POW_TOP))
            v_next = v_reg << 1;
        else if (v_reg == CW'(rcbs_pkg::POW_TOP))
            v_next = CW'(rcbs_pkg::MID_BUCKET);
        else if (v_reg == CW'(rcbs_pkg::MID_BUCKET))
            v_next = CW'(rcbs_pkg::OCT_BASE);
        else
            v_next = v_reg + (base_reg >> 2);
        if (v_next == (base_reg << 1))
            base_next = base_reg << 1;
        else
            base_next = base_reg;
    end

    always_comb
    begin
        case (ctrl.src)
            rcbs_pkg::SRC_SEL:
            begin
                bucket_next = (err_reg == rcbs_pkg::ST_OK) ? rcbs_pkg::ROWS_W'(sel) : '0;
                status_next = err_reg;
            end
            rcbs_pkg::SRC_V:
            begin
                bucket_next = rcbs_pkg::ROWS_W'(v_reg[ROW_BITS-1:0]);
                status_next = rcbs_pkg::ST_OK;
            end
            default:
            begin
                bucket_next = rcbs_pkg::ROWS_W'(cap_reg);
                status_next = rcbs_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg          <= ROW_BITS'(rcbs_pkg::OCT_BASE);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data[ROW_BITS-1:0];
            result_valid_reg <= ctrl.fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            list_reg <= cmd;
            err_reg  <= err_in;
            x_reg    <= x_in;
            p_reg    <= p_in;
            v_reg    <= CW'(rcbs_pkg::MIN_BUCKET);
            base_reg <= CW'(rcbs_pkg::OCT_BASE);
        end
        else if (ctrl.advance)
        begin
            v_reg    <= v_next;
            base_reg <= base_next;
        end
        if (ctrl.fire)
        begin
            bucket_reg <= bucket_next;
            status_reg <= status_next;
            last_reg   <= ctrl.last;
        end
    end

    assign flags.list_ok   = list_reg && (err_reg == rcbs_pkg::ST_OK);
    assign flags.cap_small = cap_small;
    assign flags.v_ge_cap  = v_reg >= cap_x;

    assign result_valid = result_valid_reg;
    assign bucket_rows  = bucket_reg;
    assign status       = status_reg;
    assign last         = last_reg;

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && status_reg != rcbs_pkg::ST_OK) |-> (bucket_reg == '0 && last_reg))
        else $error("error result with nonzero bucket or not final");

    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && status_reg == rcbs_pkg::ST_OK) |-> (bucket_reg != '0))
        else $error("ok result with zero bucket");

endmodule
`default_nettype wire

[hdl/row_capacity_bucket_select.sv]
// select: one result, registered from the entry control word; start is taken only when idle.
// list of an n-member family: one bucket per cycle from the walk step; the walk step that
// reaches the capacity emits nothing, and the capacity closes it; below 16 only the capacity.
// zero capacity or bad row count: one error result. each item's final result drops busy.
// rate is set by the control store sequencer, one control word per cycle.
// reset: idle, capacity register 1024; results cannot be stalled by the receiver.
`default_nettype none
module row_capacity_bucket_select #(
    parameter int ROW_BITS = 20
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        cmd,
    input  wire logic [rcbs_pkg::ROWS_W-1:0] active_rows,
    input  wire logic                        cfg_wr_en,
    input  wire logic [rcbs_pkg::ROWS_W-1:0] cfg_wr_data,
    output logic                             result_valid,
    output logic [rcbs_pkg::ROWS_W-1:0]      bucket_rows,
    output logic [rcbs_pkg::STATUS_W-1:0]    status,
    output logic                             last
);

    logic             accept;
    rcbs_pkg::ctrl_t  ctrl;
    rcbs_pkg::flags_t flags;

    assign accept = start && !busy;

    rcbs_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .flags  (flags),
        .busy   (busy),
        .ctrl   (ctrl)
    );

    rcbs_dp #(
        .ROW_BITS (ROW_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cmd          (cmd),
        .active_rows  (active_rows),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .ctrl         (ctrl),
        .flags        (flags),
        .result_valid (result_valid),
        .bucket_rows  (bucket_rows),
        .status       (status),
        .last         (last)
    );

endmodule
`default_nettype wire
